// ===== rtl/rk4ho_pkg.sv =====
// rk4ho_pkg: widths, register indexes, reset values, microcode codes and
// control structs shared by the rk4 harmonic oscillator modules
// no dependencies
package rk4ho_pkg;

    localparam int DW          = 32;
    localparam int STEP_W      = 24;
    localparam int ACC_W       = DW + 4;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = 5;
    localparam int DIV_W       = DIV_BITS * DIV_STEPS;
    localparam int PC_W        = 5;
    localparam int REG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 3 * DW;

    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OMEGA_SQUARED    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_POSITION = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_VELOCITY = 2'd3;

    localparam logic [STEP_W-1:0]    STEP_RESET = 24'd1677722;
    localparam logic [DW-1:0]        W2_RESET   = 32'd16777216;
    localparam logic signed [DW-1:0] X0_RESET   = 32'sd16777216;
    localparam logic signed [DW-1:0] V0_RESET   = 32'sd16777216;

    localparam logic signed [DW-1:0] VMAX    = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN    = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] NEG_TOP = {1'b1, {(DW-2){1'b0}}, 1'b1};

    localparam logic [3:0]       DIVISOR = 4'd6;
    localparam logic [ACC_W-1:0] DIV_RND = 36'd3;

    localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] PC_FINAL = 5'd20;
    localparam logic [PC_W-1:0] PC_LOAD  = 5'd21;

    typedef enum logic [2:0] {
        SEQ_NEXT     = 3'd0,
        SEQ_GOTO     = 3'd1,
        SEQ_IDLE     = 3'd2,
        SEQ_WAIT_DIV = 3'd3,
        SEQ_WAIT_OUT = 3'd4
    } seq_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_INIT  = 3'd1,
        OP_CAP_X = 3'd2,
        OP_CAP_V = 3'd3,
        OP_DIV   = 3'd4,
        OP_FINAL = 3'd5,
        OP_LOAD  = 3'd6
    } dp_op_t;

    typedef enum logic [0:0] {
        A_DT = 1'b0,
        A_W2 = 1'b1
    } a_sel_t;

    typedef enum logic [1:0] {
        B_XS  = 2'd0,
        B_VS  = 2'd1,
        B_RES = 2'd2
    } b_sel_t;

    typedef struct packed {
        logic   fire;
        dp_op_t op;
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   flip;
        logic   dbl;
        logic   full;
    } ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/rk4ho_mul.sv =====
// rk4ho_mul: shared two-stage fixed point multiplier, unsigned by signed,
// with round half away from zero, saturation and optional negation
// depends on rk4ho_pkg
module rk4ho_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic                           clk,
    input  logic [rk4ho_pkg::DW-1:0]        op_a,
    input  logic signed [rk4ho_pkg::DW-1:0] op_b,
    input  logic                           flip,
    output logic signed [rk4ho_pkg::DW-1:0] res
);
    import rk4ho_pkg::*;

    localparam int PROD_W = 2 * DW;
    localparam logic [PROD_W:0] RND = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic [DW-1:0]          mag_b;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic                   neg_reg;
    logic                   flip_reg;
    logic [PROD_W:0]        rounded;
    logic [PROD_W:0]        quot;
    logic                   over;
    logic                   out_neg;
    logic [DW-1:0]          mag_q;
    logic signed [DW-1:0]   res_reg;
    logic signed [DW-1:0]   res_next;

    assign mag_b     = op_b[DW-1] ? (~op_b + DW'(1)) : op_b;
    assign prod_next = op_a * mag_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= op_b[DW-1];
        flip_reg <= flip;
        res_reg  <= res_next;
    end

    always_comb
    begin
        rounded = {1'b0, prod_reg} + RND;
        quot    = rounded >> FRAC_BITS;
        over    = (quot[PROD_W:DW-1] != '0);
        out_neg = neg_reg ^ flip_reg;
        mag_q   = {1'b0, quot[DW-2:0]};
        if (over)
        begin
            if (out_neg)
            begin
                res_next = flip_reg ? NEG_TOP : VMIN;
            end
            else
            begin
                res_next = VMAX;
            end
        end
        else
        begin
            res_next = out_neg ? -mag_q : mag_q;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/rk4ho_div6.sv =====
// rk4ho_div6: divide by six with rounding to nearest, ties away from zero,
// eight quotient bits per cycle, positive results saturated to the state width
// depends on rk4ho_pkg
module rk4ho_div6 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rk4ho_pkg::ACC_W-1:0] sum,
    output logic                              busy,
    output logic signed [rk4ho_pkg::DW-1:0]    quot
);
    import rk4ho_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIV_W-1:0] n_reg;
    logic [DIV_W-1:0] n_next;
    logic [2:0]       rem_reg;
    logic [2:0]       rem_next;
    logic             neg_reg;
    logic             neg_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [DIV_W-1:0] n_step;
    logic [2:0]       r_step;
    logic [ACC_W-1:0] mag;
    logic [DW:0]      q_ext;
    logic [DW:0]      q_neg;

    // restoring radix-2 steps on the running remainder
    always_comb
    begin
        logic [3:0] r4;
        n_step = n_reg;
        r_step = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r4     = {r_step, n_step[DIV_W-1]};
            n_step = {n_step[DIV_W-2:0], 1'b0};
            if (r4 >= DIVISOR)
            begin
                r4        = r4 - DIVISOR;
                n_step[0] = 1'b1;
            end
            r_step = r4[2:0];
        end
    end

    always_comb
    begin
        mag       = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;
        n_next    = n_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            n_next    = {{(DIV_W-ACC_W){1'b0}}, mag + DIV_RND};
            rem_next  = 3'd0;
            neg_next  = sum[ACC_W-1];
            cnt_next  = CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next    = n_step;
            rem_next  = r_step;
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        q_ext = n_reg[DW:0];
        q_neg = ~q_ext + (DW + 1)'(1);
        if (neg_reg)
        begin
            quot = q_neg[DW-1:0];
        end
        else if (q_ext[DW:DW-1] != 2'b00)
        begin
            quot = VMAX;
        end
        else
        begin
            quot = q_ext[DW-1:0];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/rk4ho_dp.sv =====
// rk4ho_dp: datapath with configuration, state, stage operands, weighted
// sums, output register, the shared multiplier and two divide-by-six units
// depends on rk4ho_pkg, rk4ho_mul, rk4ho_div6
module rk4ho_dp #(
    parameter int FRAC_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rk4ho_pkg::ctrl_t                  ctrl,
    output rk4ho_pkg::stat_t                  stat,
    input  logic                              cfg_we,
    input  logic [rk4ho_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [rk4ho_pkg::DW-1:0]          cfg_wdata,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [rk4ho_pkg::DW-1:0]   position,
    output logic signed [rk4ho_pkg::DW-1:0]   velocity,
    output logic [rk4ho_pkg::DW-1:0]          elapsed_time
);
    import rk4ho_pkg::*;

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
        begin
            return s[DW] ? VMIN : VMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] half_tz(input logic signed [DW-1:0] a);
        logic [DW:0] s;
        s = {a[DW-1], a} + {{DW{1'b0}}, a[DW-1]};
        return s[DW:1];
    endfunction

    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DW-1:0]        w2_reg, w2_next;
    logic signed [DW-1:0] x0_reg, x0_next;
    logic signed [DW-1:0] v0_reg, v0_next;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] v_reg, v_next;
    logic [DW-1:0]        t_reg, t_next;
    logic signed [DW-1:0] xs_reg, xs_next;
    logic signed [DW-1:0] vs_reg, vs_next;
    logic signed [ACC_W-1:0] accx_reg, accx_next;
    logic signed [ACC_W-1:0] accv_reg, accv_next;
    logic signed [DW-1:0] out_pos_reg, out_pos_next;
    logic signed [DW-1:0] out_vel_reg, out_vel_next;
    logic [DW-1:0]        out_time_reg, out_time_next;
    logic                 out_valid_reg, out_valid_next;

    logic [DW-1:0]        op_a;
    logic signed [DW-1:0] op_b;
    logic signed [DW-1:0] res;
    logic signed [DW-1:0] k_term;
    logic signed [ACC_W-1:0] k_add;
    logic                 div_start;
    logic                 busy_x, busy_v;
    logic signed [DW-1:0] qx, qv;
    logic signed [DW-1:0] x_new, v_new;
    logic [DW-1:0]        t_new;

    assign op_a = (ctrl.a_sel == A_W2) ? w2_reg : {{(DW-STEP_W){1'b0}}, step_reg};

    always_comb
    begin
        case (ctrl.b_sel)
            B_XS:    op_b = xs_reg;
            B_VS:    op_b = vs_reg;
            B_RES:   op_b = res;
            default: op_b = res;
        endcase
    end

    rk4ho_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .flip (ctrl.flip),
        .res  (res)
    );

    assign div_start = ctrl.fire && (ctrl.op == OP_DIV);

    rk4ho_div6 u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (accx_reg),
        .busy  (busy_x),
        .quot  (qx)
    );

    rk4ho_div6 u_div_v (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (accv_reg),
        .busy  (busy_v),
        .quot  (qv)
    );

    assign k_term = ctrl.full ? res : half_tz(res);
    assign k_add  = ctrl.dbl ? {{(ACC_W-DW-1){res[DW-1]}}, res, 1'b0}
                             : {{(ACC_W-DW){res[DW-1]}}, res};
    assign x_new  = sat_add(x_reg, qx);
    assign v_new  = sat_add(v_reg, qv);
    assign t_new  = t_reg + {{(DW-STEP_W){1'b0}}, step_reg};

    always_comb
    begin
        step_next      = step_reg;
        w2_next        = w2_reg;
        x0_next        = x0_reg;
        v0_next        = v0_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        xs_next        = xs_reg;
        vs_next        = vs_reg;
        accx_next      = accx_reg;
        accv_next      = accv_reg;
        out_pos_next   = out_pos_reg;
        out_vel_next   = out_vel_reg;
        out_time_next  = out_time_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:        step_next = cfg_wdata[STEP_W-1:0];
                REG_OMEGA_SQUARED:    w2_next   = cfg_wdata;
                REG_INITIAL_POSITION: x0_next   = cfg_wdata;
                REG_INITIAL_VELOCITY: v0_next   = cfg_wdata;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.fire)
        begin
            case (ctrl.op)
                OP_INIT:
                begin
                    xs_next   = x_reg;
                    vs_next   = v_reg;
                    accx_next = '0;
                    accv_next = '0;
                end
                OP_CAP_X:
                begin
                    accx_next = accx_reg + k_add;
                    xs_next   = sat_add(x_reg, k_term);
                end
                OP_CAP_V:
                begin
                    accv_next = accv_reg + k_add;
                    vs_next   = sat_add(v_reg, k_term);
                end
                OP_FINAL:
                begin
                    x_next         = x_new;
                    v_next         = v_new;
                    t_next         = t_new;
                    out_pos_next   = x_new;
                    out_vel_next   = v_new;
                    out_time_next  = t_new;
                    out_valid_next = 1'b1;
                end
                OP_LOAD:
                begin
                    x_next         = x0_reg;
                    v_next         = v0_reg;
                    t_next         = '0;
                    out_pos_next   = x0_reg;
                    out_vel_next   = v0_reg;
                    out_time_next  = '0;
                    out_valid_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            w2_reg        <= W2_RESET;
            x0_reg        <= X0_RESET;
            v0_reg        <= V0_RESET;
            x_reg         <= X0_RESET;
            v_reg         <= V0_RESET;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            w2_reg        <= w2_next;
            x0_reg        <= x0_next;
            v0_reg        <= v0_next;
            x_reg         <= x_next;
            v_reg         <= v_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg       <= xs_next;
        vs_reg       <= vs_next;
        accx_reg     <= accx_next;
        accv_reg     <= accv_next;
        out_pos_reg  <= out_pos_next;
        out_vel_reg  <= out_vel_next;
        out_time_reg <= out_time_next;
    end

    assign stat.div_busy = busy_x | busy_v;
    assign stat.out_busy = out_valid_reg & ~out_ready;

    assign out_valid    = out_valid_reg;
    assign position     = out_pos_reg;
    assign velocity     = out_vel_reg;
    assign elapsed_time = out_time_reg;

endmodule

// ===== rtl/rk4ho_seq.sv =====
// rk4ho_seq: microcode sequencer with step counter, program rom and
// conditional jumps on input, divider and output status
// depends on rk4ho_pkg
module rk4ho_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_restart,
    output logic             in_ready,
    input  rk4ho_pkg::stat_t stat,
    output rk4ho_pkg::ctrl_t ctrl
);
    import rk4ho_pkg::*;

    typedef struct packed {
        seq_t            seq;
        logic [PC_W-1:0] target;
        dp_op_t          op;
        a_sel_t          a_sel;
        b_sel_t          b_sel;
        logic            flip;
        logic            dbl;
        logic            full;
    } ucode_t;

    // four rk stages of four steps, the v-side capture of a stage overlaps
    // the first product of the next one
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        w.seq    = SEQ_NEXT;
        w.target = PC_IDLE;
        w.op     = OP_NONE;
        w.a_sel  = A_DT;
        w.b_sel  = B_VS;
        w.flip   = 1'b0;
        w.dbl    = 1'b0;
        w.full   = 1'b0;
        case (addr) inside
            5'd1, 5'd5, 5'd9, 5'd13:
            begin
                w.a_sel = A_W2;
                w.b_sel = B_XS;
                w.flip  = 1'b1;
            end
            5'd2, 5'd6, 5'd10, 5'd14:
            begin
                w.a_sel = A_DT;
                w.b_sel = B_VS;
            end
            5'd3, 5'd7, 5'd11, 5'd15:
            begin
                w.a_sel = A_DT;
                w.b_sel = B_RES;
            end
            default: ;
        endcase
        case (addr) inside
            PC_IDLE:
            begin
                w.seq    = SEQ_IDLE;
                w.op     = OP_INIT;
                w.target = PC_LOAD;
            end
            5'd4, 5'd16:
            begin
                w.op = OP_CAP_X;
            end
            5'd8:
            begin
                w.op  = OP_CAP_X;
                w.dbl = 1'b1;
            end
            5'd12:
            begin
                w.op   = OP_CAP_X;
                w.dbl  = 1'b1;
                w.full = 1'b1;
            end
            5'd5, 5'd17:
            begin
                w.op = OP_CAP_V;
            end
            5'd9:
            begin
                w.op  = OP_CAP_V;
                w.dbl = 1'b1;
            end
            5'd13:
            begin
                w.op   = OP_CAP_V;
                w.dbl  = 1'b1;
                w.full = 1'b1;
            end
            5'd18:
            begin
                w.op = OP_DIV;
            end
            5'd19:
            begin
                w.seq    = SEQ_WAIT_DIV;
                w.target = PC_FINAL;
            end
            PC_FINAL:
            begin
                w.seq    = SEQ_WAIT_OUT;
                w.op     = OP_FINAL;
                w.target = PC_IDLE;
            end
            PC_LOAD:
            begin
                w.seq    = SEQ_WAIT_OUT;
                w.op     = OP_LOAD;
                w.target = PC_IDLE;
            end
            [5'd22:5'd31]:
            begin
                w.seq    = SEQ_GOTO;
                w.target = PC_IDLE;
            end
            default: ;
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            fire;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        pc_next  = pc_reg;
        fire     = 1'b0;
        in_ready = 1'b0;
        case (word.seq)
            SEQ_NEXT:
            begin
                fire    = 1'b1;
                pc_next = pc_reg + PC_W'(1);
            end
            SEQ_GOTO:
            begin
                fire    = 1'b1;
                pc_next = word.target;
            end
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fire    = 1'b1;
                    pc_next = in_restart ? word.target : pc_reg + PC_W'(1);
                end
            end
            SEQ_WAIT_DIV:
            begin
                if (!stat.div_busy)
                begin
                    fire    = 1'b1;
                    pc_next = word.target;
                end
            end
            SEQ_WAIT_OUT:
            begin
                if (!stat.out_busy)
                begin
                    fire    = 1'b1;
                    pc_next = word.target;
                end
            end
            default: pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.fire  = fire;
    assign ctrl.op    = word.op;
    assign ctrl.a_sel = word.a_sel;
    assign ctrl.b_sel = word.b_sel;
    assign ctrl.flip  = word.flip;
    assign ctrl.dbl   = word.dbl;
    assign ctrl.full  = word.full;

endmodule

// ===== rtl/rk4_harmonic_oscillator_step.sv =====
// rk4_harmonic_oscillator_step: top level, rk4 step of x'' = -w2*x in Q8.24
// a time step, once accepted, runs the products and captures on the shared multiplier,
// a divider start, the divide steps, the wait for the divider and the update, which waits
// for a free output; no new item is taken until the update has fired
// a restart goes to the load word, which waits for a free output, then loads x0, v0 and time 0
// reset: registers to defaults, position and velocity 1.0, time 0, no clearing
module rk4_harmonic_oscillator_step #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rk4ho_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rk4ho_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // position, velocity, elapsed_time
    input  logic                                cfg_we,
    input  logic [rk4ho_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [rk4ho_pkg::DW-1:0]            cfg_wdata
);
    import rk4ho_pkg::*;

    ctrl_t                ctrl;
    stat_t                stat;
    logic signed [DW-1:0] position;
    logic signed [DW-1:0] velocity;
    logic [DW-1:0]        elapsed_time;

    rk4ho_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_restart (s_axis_tdata[0]),
        .in_ready   (s_axis_tready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    rk4ho_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .position     (position),
        .velocity     (velocity),
        .elapsed_time (elapsed_time)
    );

    assign m_axis_tdata = {elapsed_time, velocity, position};

endmodule

// ===== rtl/rk4ho_checker.sv =====
// rk4ho_checker: port-level assertions for rk4_harmonic_oscillator_step,
// attached to the top level by the bind below
// depends on rk4ho_pkg and rk4_harmonic_oscillator_step
module rk4ho_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [rk4ho_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rk4ho_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rk4ho_pkg::*;

    // result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one item in flight: no input taken right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // restart with a free output shows zero time once the load word has registered it
    a_restart_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] && !m_axis_tvalid
        |=> ##1 m_axis_tvalid && (m_axis_tdata[OUT_TDATA_W-1:2*DW] == '0))
        else $error("restart result missing or time not cleared");

    // a time step never delivers its result in the next cycle
    a_step_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("step result appeared too early");

endmodule

bind rk4_harmonic_oscillator_step rk4ho_checker u_rk4ho_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/testbench.sv =====
// testbench: self-checking bench for rk4_harmonic_oscillator_step, a directed table then random
// phases over the register settings, each result checked against table gold or local rk4 model
// depends on rtl/rk4ho_pkg.sv and rtl/rk4_harmonic_oscillator_step.sv
module testbench;
    import rk4ho_pkg::*;

    localparam int FRAC = 24;
    localparam longint TOP = 64'sd2147483647;
    localparam logic [7:0] WORD_STEP = 8'h00;
    localparam logic [7:0] WORD_RESTART = 8'h01;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [DW-1:0] elapsed;
        logic [DW-1:0] velocity;
        logic [DW-1:0] position;
    } state_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STINGY,
        RX_BEAT
    } rx_mode_t;

    typedef struct {
        row_kind_t             kind;
        logic [REG_IDX_W-1:0]  index;
        logic [DW-1:0]         value;
        bit                    has_gold;
        state_t                gold;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // position, velocity, elapsed_time
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [DW-1:0]          cfg_wdata;

    // shadow of the block's registers and state
    logic [STEP_W-1:0] step_q = STEP_RESET;
    logic [DW-1:0]     w2_q   = W2_RESET;
    logic [DW-1:0]     x0_q   = X0_RESET;
    logic [DW-1:0]     v0_q   = V0_RESET;
    longint            pos_q  = longint'(X0_RESET);
    longint            vel_q  = longint'(V0_RESET);
    logic [DW-1:0]     time_q = '0;

    state_t expected_states [$];
    int     mismatch_count = 0;
    int     burst_left = 0;

    row_t plan [34] = '{
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_RESTART,  1'b1, {32'h0, 32'h01000000, 32'h01000000}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        32'hFE,        1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        32'hFF,        1'b1, {32'h0, 32'h01000000, 32'h01000000}},
        '{ROW_WRITE, REG_STEP_SIZE,        32'hFF000000,  1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b1, {32'h0, 32'h01000000, 32'h01000000}},
        '{ROW_ITEM,  REG_STEP_SIZE,        32'h80,        1'b1, {32'h0, 32'h01000000, 32'h01000000}},
        '{ROW_WRITE, REG_STEP_SIZE,        32'h00FFFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_OMEGA_SQUARED,    32'hFFFFFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_POSITION, 32'h80000000,  1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_VELOCITY, 32'h7FFFFFFF,  1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_RESTART,  1'b1, {32'h0, 32'h7FFFFFFF, 32'h80000000}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_POSITION, 32'h7FFFFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_VELOCITY, 32'h80000000,  1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_RESTART,  1'b1, {32'h0, 32'h80000000, 32'h7FFFFFFF}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_WRITE, REG_OMEGA_SQUARED,    32'h0,         1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_POSITION, 32'h0,         1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_VELOCITY, 32'h0,         1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_RESTART,  1'b1, {32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b1, {32'h00FFFFFF, 32'h0, 32'h0}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b1, {32'h01FFFFFE, 32'h0, 32'h0}},
        '{ROW_WRITE, REG_STEP_SIZE,        32'(STEP_RESET), 1'b0, '0},
        '{ROW_WRITE, REG_OMEGA_SQUARED,    W2_RESET,      1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_POSITION, 32'hFF000000,  1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_RESTART,  1'b1, {32'h0, 32'h0, 32'hFF000000}},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0},
        '{ROW_ITEM,  REG_STEP_SIZE,        WORD_STEP,     1'b0, '0}
    };

    rk4_harmonic_oscillator_step u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    function automatic logic [63:0] magnitude(input longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint from_magnitude(input bit neg, input logic [127:0] m);
        if (m > 128'(TOP))
            return neg ? -TOP - 1 : TOP;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint sat32(input longint a);
        if (a > TOP)
            return TOP;
        if (a < -TOP - 1)
            return -TOP - 1;
        return a;
    endfunction

    // rounded fixed-point product, ties away from zero, saturating
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] prod;
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
        return from_magnitude((a < 0) != (b < 0), prod);
    endfunction

    function automatic longint acceleration(input longint x);
        longint f;
        f = fx_mul(longint'(w2_q), x);
        return from_magnitude(!(f < 0), {64'd0, magnitude(f)});
    endfunction

    // weighted rk4 sum divided by six, rounded to nearest
    function automatic longint rk_blend(input longint k1, input longint k2, input longint k3,
                                        input longint k4);
        longint       total;
        logic [127:0] m;
        total = k1 + k4 + 2 * k2 + 2 * k3;
        m = {64'd0, magnitude(total)};
        return from_magnitude(total < 0, m / 6 + (((m % 6) >= 3) ? 128'd1 : 128'd0));
    endfunction

    task automatic advance_oscillator(input logic [7:0] word, output state_t next);
        longint dt, x, v, xa, va, xb, vb, xc, vc;
        longint k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
        if (word[0])
        begin
            pos_q = longint'($signed(x0_q));
            vel_q = longint'($signed(v0_q));
            time_q = '0;
        end
        else
        begin
            dt = longint'(step_q);
            x = pos_q;
            v = vel_q;
            k1x = fx_mul(dt, v);
            k1v = fx_mul(dt, acceleration(x));
            xa = sat32(x + k1x / 2);
            va = sat32(v + k1v / 2);
            k2x = fx_mul(dt, va);
            k2v = fx_mul(dt, acceleration(xa));
            xb = sat32(x + k2x / 2);
            vb = sat32(v + k2v / 2);
            k3x = fx_mul(dt, vb);
            k3v = fx_mul(dt, acceleration(xb));
            xc = sat32(x + k3x);
            vc = sat32(v + k3v);
            k4x = fx_mul(dt, vc);
            k4v = fx_mul(dt, acceleration(xc));
            pos_q = sat32(x + rk_blend(k1x, k2x, k3x, k4x));
            vel_q = sat32(v + rk_blend(k1v, k2v, k3v, k4v));
            time_q = time_q + DW'(step_q);
        end
        next.position = pos_q[DW-1:0];
        next.velocity = vel_q[DW-1:0];
        next.elapsed = time_q;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_SIZE:        step_q = data[STEP_W-1:0];
            REG_OMEGA_SQUARED:    w2_q = data;
            REG_INITIAL_POSITION: x0_q = data;
            REG_INITIAL_VELOCITY: v0_q = data;
            default: ;
        endcase
    endtask

    // stop offering and wait until every outstanding transaction has come back
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic offer_item(input logic [7:0] word, input bit has_gold, input state_t gold);
        state_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_oscillator(word, predicted);
        expected_states.push_back(has_gold ? gold : predicted);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 20);
        end
        else
            burst_left--;
    endtask

    function automatic logic [DW-1:0] pick_setting(input logic [REG_IDX_W-1:0] idx);
        int unsigned roll;
        roll = $urandom_range(0, 5);
        case (idx)
            REG_STEP_SIZE:
                case (roll)
                    0: return {8'($urandom), 24'h0};
                    1: return {8'($urandom), 24'hFFFFFF};
                    default: return {8'($urandom), 24'($urandom_range(1, 32'h40_0000))};
                endcase
            REG_OMEGA_SQUARED:
                case (roll)
                    0: return 32'h0;
                    1: return 32'hFFFFFFFF;
                    2: return $urandom;
                    default: return $urandom_range(0, 32'h0800_0000);
                endcase
            default:
                case (roll)
                    0: return 32'h80000000;
                    1: return 32'h7FFFFFFF;
                    2: return $urandom;
                    default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                endcase
        endcase
        return '0;
    endfunction

    // receiver: changing stall patterns plus a long hold now and then
    initial
    begin : receiver
        int unsigned cycle_count;
        int unsigned hold_left;
        rx_mode_t    mode;
        cycle_count = 0;
        hold_left = 0;
        mode = RX_OPEN;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count % 6000 == 1500)
                hold_left = 400;
            if (cycle_count % 64 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_STINGY: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (cycle_count % 3 != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        state_t got;
        state_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = state_t'(m_axis_tdata);
            if (expected_states.size() == 0)
                flag_mismatch("unexpected transaction", got.position, '0);
            else
            begin
                want = expected_states.pop_front();
                if (got.position !== want.position)
                    flag_mismatch("position", got.position, want.position);
                if (got.velocity !== want.velocity)
                    flag_mismatch("velocity", got.velocity, want.velocity);
                if (got.elapsed !== want.elapsed)
                    flag_mismatch("elapsed_time", got.elapsed, want.elapsed);
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int count;
        int restart_odds;
        bit restart;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_STEP_SIZE;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(plan[i].index, plan[i].value);
            end
            else
                offer_item(plan[i].value[7:0], plan[i].has_gold, plan[i].gold);
        end

        // first phase runs long at the largest step so the time wraps
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            settle_block();
            if (phase == 0)
            begin
                write_reg(REG_STEP_SIZE, 32'hFFFFFFFF);
                count = 300;
                restart_odds = 0;
            end
            else
            begin
                if ($urandom_range(0, 1))
                    write_reg(REG_STEP_SIZE, pick_setting(REG_STEP_SIZE));
                if ($urandom_range(0, 1))
                    write_reg(REG_OMEGA_SQUARED, pick_setting(REG_OMEGA_SQUARED));
                if ($urandom_range(0, 1))
                    write_reg(REG_INITIAL_POSITION, pick_setting(REG_INITIAL_POSITION));
                if ($urandom_range(0, 1))
                    write_reg(REG_INITIAL_VELOCITY, pick_setting(REG_INITIAL_VELOCITY));
                count = $urandom_range(60, 140);
                restart_odds = ($urandom_range(0, 2) == 0) ? 0 : 30;
            end
            for (int n = 0; n < count; n++)
            begin
                restart = (phase != 0 && n == 0 && $urandom_range(0, 1) == 1)
                          || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
                offer_item({7'($urandom), restart}, 1'b0, '0);
                sent++;
            end
        end

        settle_block();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== rk4_harmonic_oscillator_step.f =====
rtl/rk4ho_pkg.sv
rtl/rk4ho_mul.sv
rtl/rk4ho_div6.sv
rtl/rk4ho_dp.sv
rtl/rk4ho_seq.sv
rtl/rk4_harmonic_oscillator_step.sv
rtl/rk4ho_checker.sv
dv/testbench.sv
